### hw/rtl/function_time_profiler_table_macros.svh
// ----------------------------------------------------------------------------
// Function time profiler table - assertion macros
// Shared concurrent assertion forms for the profiler checkers.
// ----------------------------------------------------------------------------
`ifndef FUNCTION_TIME_PROFILER_TABLE_MACROS_SVH
`define FUNCTION_TIME_PROFILER_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define FTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ftp_pkg.sv
// ----------------------------------------------------------------------------
// Function time profiler package
// Codes, state types and constants shared by the profiler modules.
// ----------------------------------------------------------------------------
package ftp_pkg;

    localparam int DEF_TABLE_DEPTH  = 64;
    localparam int DEF_NESTING_BITS = 16;

    // Microseconds per second, fits in 20 bits
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    typedef enum logic [1:0] {
        ACT_ENTER = 2'd0,
        ACT_EXIT  = 2'd1,
        ACT_DUMP  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TABLE_FULL   = 3'd1,
        ST_EXIT_UNKNOWN = 3'd2,
        ST_DEPTH_SAT    = 3'd3,
        ST_DUMP         = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CALC,
        B_ADD,
        B_DUMP,
        B_DTAIL
    } t_bstate;

endpackage

### hw/rtl/ftp_front.sv
// ----------------------------------------------------------------------------
// Profiler front end
// Accepts events, matches the address against the tag table, allocates new
// slots and converts the timestamp to microseconds before queuing.
// ----------------------------------------------------------------------------
module ftp_front import ftp_pkg::*; #(
    parameter  int TABLE_DEPTH = DEF_TABLE_DEPTH,
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_action,
    input  logic [63:0]       i_function_addr,
    input  logic [31:0]       i_time_sec,
    input  logic [19:0]       i_time_usec,
    output logic              o_busy,
    input  logic              i_q_full,
    output logic              o_push,
    output logic [1:0]        o_action,
    output logic [63:0]       o_fn,
    output logic [63:0]       o_now,
    output logic              o_hit,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_full,
    output logic [CNT_W-1:0]  o_cnt
);

    logic [63:0]       r_tag [TABLE_DEPTH];
    logic [CNT_W-1:0]  r_used;
    logic              r_fv;
    logic [1:0]        r_action;
    logic [63:0]       r_fn;
    logic [51:0]       r_prod;
    logic [19:0]       r_usec;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic              r_full;
    logic [CNT_W-1:0]  r_cnt;

    logic              m_hit;
    logic [SLOT_W-1:0] m_idx;
    logic              tbl_full;
    logic              accept;
    logic              append;

    // Match the incoming address against every used tag; tags are unique
    always_comb begin
        m_hit = 1'b0;
        m_idx = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if ((CNT_W'(k) < r_used) && (r_tag[k] == i_function_addr)) begin
                m_hit = 1'b1;
                m_idx = m_idx | SLOT_W'(k);
            end
        end
    end

    assign tbl_full = (r_used == CNT_W'(TABLE_DEPTH));
    assign accept   = i_start & ~r_fv;
    assign append   = accept & (t_action'(i_action) == ACT_ENTER) & ~m_hit & ~tbl_full;

    // Hold the staged event until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv   <= 1'b0;
            r_used <= '0;
        end else begin
            if (accept) begin
                r_fv <= 1'b1;
            end else if (r_fv && !i_q_full) begin
                r_fv <= 1'b0;
            end
            if (append) begin
                r_used <= r_used + CNT_W'(1);
            end
        end
    end

    // Capture the classified event and allocate a tag on a new address
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_fn     <= i_function_addr;
            r_prod   <= 52'(i_time_sec) * 52'(USEC_PER_SEC);
            r_usec   <= i_time_usec;
            r_hit    <= m_hit;
            r_slot   <= m_hit ? m_idx : r_used[SLOT_W-1:0];
            r_full   <= tbl_full;
            r_cnt    <= r_used;
        end
        if (append) begin
            r_tag[r_used[SLOT_W-1:0]] <= i_function_addr;
        end
    end

    // Finish the timestamp and push into the queue
    assign o_busy   = r_fv;
    assign o_push   = r_fv & ~i_q_full;
    assign o_action = r_action;
    assign o_fn     = r_fn;
    assign o_now    = {12'd0, r_prod} + {44'd0, r_usec};
    assign o_hit    = r_hit;
    assign o_slot   = r_slot;
    assign o_full   = r_full;
    assign o_cnt    = r_cnt;

endmodule

### hw/rtl/ftp_queue.sv
// ----------------------------------------------------------------------------
// Profiler command queue
// Two-entry FIFO that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
module ftp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_slot[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hw/rtl/ftp_back.sv
// ----------------------------------------------------------------------------
// Profiler table engine
// Read-modify-write of one slot per event, and the dump sweep over the
// used slots in insertion order. Drives the result strobe.
// ----------------------------------------------------------------------------
module ftp_back import ftp_pkg::*; #(
    parameter  int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter  int NESTING_BITS = DEF_NESTING_BITS,
    localparam int SLOT_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic [1:0]        i_action,
    input  logic [63:0]       i_fn,
    input  logic [63:0]       i_now,
    input  logic              i_hit,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_full,
    input  logic [CNT_W-1:0]  i_cnt,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output logic [63:0]       o_entry_function,
    output logic [63:0]       o_entry_total_time,
    output logic              o_last_of_run
);

    localparam logic [NESTING_BITS-1:0] NEST_MAX = {NESTING_BITS{1'b1}};

    // Slot storage
    logic [63:0]             m_func  [TABLE_DEPTH];
    logic [NESTING_BITS-1:0] m_nest  [TABLE_DEPTH];
    logic [63:0]             m_start [TABLE_DEPTH];
    logic [63:0]             m_total [TABLE_DEPTH];

    logic [63:0]             r_rd_func;
    logic [NESTING_BITS-1:0] r_rd_nest;
    logic [63:0]             r_rd_start;
    logic [63:0]             r_rd_total;

    t_bstate           r_state, n_state;
    t_action           r_action;
    logic [63:0]       r_fn;
    logic [63:0]       r_now;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_cnt;
    logic [SLOT_W-1:0] r_idx;
    logic [63:0]       r_diff;
    logic              r_dv;
    logic              r_dlast;

    logic                    we;
    logic [SLOT_W-1:0]       w_addr;
    logic [63:0]             w_func;
    logic [NESTING_BITS-1:0] w_nest;
    logic [63:0]             w_start;
    logic [63:0]             w_total;
    logic [SLOT_W-1:0]       rd_addr;
    logic                    dump_rd;
    logic                    dump_last;
    logic                    ld_diff;
    logic                    emit;
    t_status                 e_status;
    logic [63:0]             e_fn;
    logic [63:0]             e_total;
    logic                    o_emit;
    t_status                 o_emit_status;
    logic [63:0]             o_emit_fn;
    logic [63:0]             o_emit_total;
    logic                    o_emit_last;
    logic [63:0]             sum_total;
    logic                    dump_end;
    t_action                 h_action;

    assign h_action  = t_action'(i_action);
    assign sum_total = r_rd_total + r_diff;
    assign dump_end  = (CNT_W'(r_idx) == (r_cnt - CNT_W'(1)));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    case (h_action)
                        ACT_ENTER, ACT_EXIT: begin
                            if (i_hit) begin
                                n_state = B_CALC;
                            end
                        end
                        ACT_DUMP: begin
                            if (i_cnt != '0) begin
                                n_state = (i_cnt == CNT_W'(1)) ? B_DTAIL : B_DUMP;
                            end
                        end
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_CALC: begin
                if ((r_action == ACT_EXIT) && (r_rd_nest <= NESTING_BITS'(1))) begin
                    n_state = B_ADD;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_ADD:   n_state = B_IDLE;
            B_DUMP: begin
                if (dump_end) begin
                    n_state = B_DTAIL;
                end
            end
            B_DTAIL: n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Datapath controls per state
    always_comb begin
        o_pop     = 1'b0;
        we        = 1'b0;
        w_addr    = r_slot;
        w_func    = r_fn;
        w_nest    = r_rd_nest;
        w_start   = r_rd_start;
        w_total   = r_rd_total;
        rd_addr   = r_slot;
        dump_rd   = 1'b0;
        dump_last = 1'b0;
        ld_diff   = 1'b0;
        emit      = 1'b0;
        e_status  = ST_OK;
        e_fn      = r_fn;
        e_total   = r_rd_total;
        unique case (r_state)
            B_IDLE: begin
                rd_addr = (h_action == ACT_DUMP) ? '0 : i_slot;
                w_addr  = i_slot;
                w_func  = i_fn;
                w_nest  = NESTING_BITS'(1);
                w_start = i_now;
                w_total = '0;
                e_fn    = i_fn;
                e_total = '0;
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (h_action)
                        ACT_ENTER: begin
                            if (!i_hit) begin
                                emit = 1'b1;
                                if (i_full) begin
                                    e_status = ST_TABLE_FULL;
                                end else begin
                                    we = 1'b1;
                                end
                            end
                        end
                        ACT_EXIT: begin
                            if (!i_hit) begin
                                emit     = 1'b1;
                                e_status = ST_EXIT_UNKNOWN;
                            end
                        end
                        ACT_DUMP: begin
                            if (i_cnt != '0) begin
                                dump_rd   = 1'b1;
                                dump_last = (i_cnt == CNT_W'(1));
                            end
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            B_CALC: begin
                if (r_action == ACT_EXIT) begin
                    if (r_rd_nest > NESTING_BITS'(1)) begin
                        we     = 1'b1;
                        w_nest = r_rd_nest - NESTING_BITS'(1);
                        emit   = 1'b1;
                    end else begin
                        ld_diff = 1'b1;
                    end
                end else if (r_rd_nest == '0) begin
                    we      = 1'b1;
                    w_nest  = NESTING_BITS'(1);
                    w_start = r_now;
                    emit    = 1'b1;
                end else if (r_rd_nest == NEST_MAX) begin
                    emit     = 1'b1;
                    e_status = ST_DEPTH_SAT;
                end else begin
                    we     = 1'b1;
                    w_nest = r_rd_nest + NESTING_BITS'(1);
                    emit   = 1'b1;
                end
            end
            B_ADD: begin
                we      = 1'b1;
                w_nest  = '0;
                w_total = sum_total;
                emit    = 1'b1;
                e_total = sum_total;
            end
            B_DUMP: begin
                rd_addr   = r_idx;
                dump_rd   = 1'b1;
                dump_last = dump_end;
            end
            B_DTAIL: begin
                rd_addr = r_slot;
            end
            default: rd_addr = r_slot;
        endcase
    end

    // Dump entries take the result port while the sweep runs
    always_comb begin
        if (r_dv) begin
            o_emit        = 1'b1;
            o_emit_status = ST_DUMP;
            o_emit_fn     = r_rd_func;
            o_emit_total  = r_rd_total;
            o_emit_last   = r_dlast;
        end else begin
            o_emit        = emit;
            o_emit_status = e_status;
            o_emit_fn     = e_fn;
            o_emit_total  = e_total;
            o_emit_last   = 1'b1;
        end
    end

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            m_func[w_addr]  <= w_func;
            m_nest[w_addr]  <= w_nest;
            m_start[w_addr] <= w_start;
            m_total[w_addr] <= w_total;
        end
        r_rd_func  <= m_func[rd_addr];
        r_rd_nest  <= m_nest[rd_addr];
        r_rd_start <= m_start[rd_addr];
        r_rd_total <= m_total[rd_addr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_dv    <= 1'b0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= dump_rd;
            o_valid <= o_emit;
            if (o_pop) begin
                r_idx <= SLOT_W'(1);
            end else if (r_state == B_DUMP) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
        end
    end

    // Command and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_action <= h_action;
            r_fn     <= i_fn;
            r_now    <= i_now;
            r_slot   <= i_slot;
            r_cnt    <= i_cnt;
        end
        if (ld_diff) begin
            r_diff <= r_now - r_rd_start;
        end
        r_dlast            <= dump_last;
        o_status           <= o_emit_status;
        o_entry_function   <= o_emit_fn;
        o_entry_total_time <= o_emit_total;
        o_last_of_run      <= o_emit_last;
    end

endmodule

### hw/rtl/function_time_profiler_table.sv
// A miss or drop reports from the table engine's idle state, a hit from the
// calc state after its slot is read, and an exit that closes its outermost
// call from the add state after that. The front end's staging register holds
// one event, with busy high, until the queue takes it; the table engine steps
// through these states or a dump sweep, and the two-entry queue absorbs the gap.
// Reset clears the slot count and all control; slot contents need no clear.
// ----------------------------------------------------------------------------
// Function time profiler table
// Per-function nesting depth and accumulated time with insertion-order dump.
// ----------------------------------------------------------------------------
module function_time_profiler_table import ftp_pkg::*; #(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int NESTING_BITS = DEF_NESTING_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_function_addr,
    input  logic [31:0] i_time_sec,
    input  logic [19:0] i_time_usec,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [63:0] o_entry_function,
    output logic [63:0] o_entry_total_time,
    output logic        o_last_of_run
);

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int PW     = 2 + 64 + 64 + 1 + SLOT_W + 1 + CNT_W;

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    logic [PW-1:0]     q_wdata;
    logic [PW-1:0]     q_rdata;

    logic [1:0]        f_action;
    logic [63:0]       f_fn;
    logic [63:0]       f_now;
    logic              f_hit;
    logic [SLOT_W-1:0] f_slot;
    logic              f_full;
    logic [CNT_W-1:0]  f_cnt;

    logic [1:0]        b_action;
    logic [63:0]       b_fn;
    logic [63:0]       b_now;
    logic              b_hit;
    logic [SLOT_W-1:0] b_slot;
    logic              b_full;
    logic [CNT_W-1:0]  b_cnt;

    ftp_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_action        (i_action),
        .i_function_addr (i_function_addr),
        .i_time_sec      (i_time_sec),
        .i_time_usec     (i_time_usec),
        .o_busy          (busy),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_action        (f_action),
        .o_fn            (f_fn),
        .o_now           (f_now),
        .o_hit           (f_hit),
        .o_slot          (f_slot),
        .o_full          (f_full),
        .o_cnt           (f_cnt)
    );

    // Pack the classified event for the queue
    assign q_wdata = {f_action, f_fn, f_now, f_hit, f_slot, f_full, f_cnt};
    assign {b_action, b_fn, b_now, b_hit, b_slot, b_full, b_cnt} = q_rdata;

    ftp_queue #(
        .WIDTH (PW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    ftp_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .NESTING_BITS (NESTING_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (q_empty),
        .o_pop              (q_pop),
        .i_action           (b_action),
        .i_fn               (b_fn),
        .i_now              (b_now),
        .i_hit              (b_hit),
        .i_slot             (b_slot),
        .i_full             (b_full),
        .i_cnt              (b_cnt),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_entry_function   (o_entry_function),
        .o_entry_total_time (o_entry_total_time),
        .o_last_of_run      (o_last_of_run)
    );

endmodule

### hw/rtl/ftp_checker.sv
// ----------------------------------------------------------------------------
// Function time profiler checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "function_time_profiler_table_macros.svh"

module ftp_checker import ftp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_status,
    input logic [63:0] o_entry_total_time,
    input logic        o_last_of_run
);

    // An accepted event occupies the front end for the next cycle
    `FTP_ASSERT_NXT(a_busy_after_transfer, i_clk, i_rst_n, start && !busy, busy, "busy not raised after start transfer")

    // Results other than dump entries stand alone and carry the last flag
    `FTP_ASSERT_IMP(a_single_is_last, i_clk, i_rst_n, o_valid && (o_status != ST_DUMP), o_last_of_run, "single result without last flag")

    // Dropped and unknown events report no accumulated time
    `FTP_ASSERT_IMP(a_reject_zero_total, i_clk, i_rst_n, o_valid && ((o_status == ST_TABLE_FULL) || (o_status == ST_EXIT_UNKNOWN)), o_entry_total_time == 64'd0, "rejected event with nonzero total")

    // A dump run streams without gaps until its last entry
    `FTP_ASSERT_NXT(a_dump_contiguous, i_clk, i_rst_n, o_valid && (o_status == ST_DUMP) && !o_last_of_run, o_valid && (o_status == ST_DUMP), "gap inside dump run")

endmodule

bind function_time_profiler_table ftp_checker u_ftp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_status           (o_status),
    .o_entry_total_time (o_entry_total_time),
    .o_last_of_run      (o_last_of_run)
);

### tb/tb_function_time_profiler_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Function time profiler table - testbench
// Drives enter, exit and dump events through the start/busy port. A local
// copy of the profiler table predicts every report, and each strobed report
// is compared field by field in arrival order. The run covers directed corner
// cases, random balanced call traces, a full table and deep nesting.
// ----------------------------------------------------------------------------
module tb_function_time_profiler_table;
    import ftp_pkg::*;

    localparam int  TABLE_SLOTS = DEF_TABLE_DEPTH;
    localparam int  NEST_BITS   = DEF_NESTING_BITS;
    localparam int  CYCLE_LIMIT = 1_500_000;
    localparam int  BURST_LEN   = 8;

    typedef struct {
        t_action     action;
        logic [63:0] func;
        logic [31:0] sec;
        logic [19:0] usec;
        int          gap;
        bit          hold;
    } t_event;

    typedef struct {
        t_status     status;
        logic [63:0] func;
        logic [63:0] total;
        logic        last;
    } t_report;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        start              = 1'b0;
    logic [1:0]  i_action           = '0;
    logic [63:0] i_function_addr    = '0;
    logic [31:0] i_time_sec         = '0;
    logic [19:0] i_time_usec        = '0;
    logic        busy;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [63:0] o_entry_function;
    logic [63:0] o_entry_total_time;
    logic        o_last_of_run;

    // Pending stimulus and expected reports
    t_event      pending_events[$];
    t_report     expected_reports[$];

    // Local copy of the profiler table
    logic [63:0]          prof_func  [TABLE_SLOTS];
    logic [NEST_BITS-1:0] prof_depth [TABLE_SLOTS];
    logic [63:0]          prof_start [TABLE_SLOTS];
    logic [63:0]          prof_total [TABLE_SLOTS];
    int                   prof_used = 0;

    // Driver state
    t_event      cur_event;
    bit          driving  = 1'b0;
    bit          staged   = 1'b0;
    bit          took     = 1'b0;
    int          hold_cnt = 0;

    int          error_cnt = 0;
    int          cycle_cnt = 0;
    t_report     got_report;

    // Trace clock used while building stimulus
    logic [31:0] trace_sec;
    logic [19:0] trace_usec;

    function_time_profiler_table #(
        .TABLE_DEPTH  (DEF_TABLE_DEPTH),
        .NESTING_BITS (DEF_NESTING_BITS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_function_addr    (i_function_addr),
        .i_time_sec         (i_time_sec),
        .i_time_usec        (i_time_usec),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_entry_function   (o_entry_function),
        .o_entry_total_time (o_entry_total_time),
        .o_last_of_run      (o_last_of_run)
    );

    // Clock and reset
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Profiler prediction
    // ------------------------------------------------------------------
    function automatic void queue_report(t_status st, logic [63:0] fn, logic [63:0] tot,
                                         logic last);
        t_report r;
        r.status = st;
        r.func   = fn;
        r.total  = tot;
        r.last   = last;
        expected_reports.push_back(r);
    endfunction

    function automatic void profile_event(t_event ev);
        logic [63:0] now_us;
        int          slot;
        now_us = 64'(ev.sec) * 64'd1000000 + 64'(ev.usec);
        slot   = -1;
        for (int k = 0; k < prof_used; k++) begin
            if (slot < 0 && prof_func[k] == ev.func) slot = k;
        end
        case (ev.action)
            ACT_ENTER: begin
                if (slot >= 0) begin
                    // Saturated depth leaves the entry untouched
                    if (prof_depth[slot] == '1) begin
                        queue_report(ST_DEPTH_SAT, ev.func, prof_total[slot], 1'b1);
                    end else begin
                        if (prof_depth[slot] != '0) begin
                            prof_depth[slot] = prof_depth[slot] + 1'b1;
                        end else begin
                            prof_start[slot] = now_us;
                            prof_depth[slot] = NEST_BITS'(1);
                        end
                        queue_report(ST_OK, ev.func, prof_total[slot], 1'b1);
                    end
                end else if (prof_used >= TABLE_SLOTS) begin
                    queue_report(ST_TABLE_FULL, ev.func, 64'd0, 1'b1);
                end else begin
                    prof_func[prof_used]  = ev.func;
                    prof_depth[prof_used] = NEST_BITS'(1);
                    prof_start[prof_used] = now_us;
                    prof_total[prof_used] = 64'd0;
                    prof_used++;
                    queue_report(ST_OK, ev.func, 64'd0, 1'b1);
                end
            end
            ACT_EXIT: begin
                if (slot < 0) begin
                    queue_report(ST_EXIT_UNKNOWN, ev.func, 64'd0, 1'b1);
                end else begin
                    // Close the outermost call, also when already closed
                    if (prof_depth[slot] > 1) begin
                        prof_depth[slot] = prof_depth[slot] - 1'b1;
                    end else begin
                        prof_total[slot] = prof_total[slot] + (now_us - prof_start[slot]);
                        prof_depth[slot] = '0;
                    end
                    queue_report(ST_OK, ev.func, prof_total[slot], 1'b1);
                end
            end
            ACT_DUMP: begin
                for (int k = 0; k < prof_used; k++) begin
                    queue_report(ST_DUMP, prof_func[k], prof_total[k], k == prof_used - 1);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic void add_event(t_action a, logic [63:0] fn, logic [31:0] s,
                                      logic [19:0] u, int gap, bit hold);
        t_event ev;
        ev.action = a;
        ev.func   = fn;
        ev.sec    = s;
        ev.usec   = u;
        ev.gap    = gap;
        ev.hold   = hold;
        pending_events.push_back(ev);
    endfunction

    // Advance the trace clock and queue an event stamped with it
    function automatic void add_traced(t_action a, logic [63:0] fn, int gap, bit hold);
        int step;
        step = $urandom_range(0, 300000);
        if (int'(trace_usec) + step >= 1000000) begin
            trace_usec = 20'(int'(trace_usec) + step - 1000000);
            trace_sec  = trace_sec + 1;
        end else begin
            trace_usec = 20'(int'(trace_usec) + step);
        end
        add_event(a, fn, trace_sec, trace_usec, gap, hold);
    endfunction

    function automatic logic [63:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // Mostly balanced call traces over a small address pool, with noise
    function automatic void add_random_trace(int count, ref logic [63:0] pool[16],
                                             ref logic [63:0] open_calls[$]);
        int  r;
        bit  quiet;
        quiet = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) quiet = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 80 && open_calls.size() == 0)) begin
                open_calls.push_back(pool[$urandom_range(0, 15)]);
                add_traced(ACT_ENTER, open_calls[$], pick_gap(quiet), 1'b0);
            end else if (r < 80) begin
                add_traced(ACT_EXIT, open_calls.pop_back(), pick_gap(quiet), 1'b0);
            end else if (r < 85) begin
                add_traced(ACT_DUMP, rand_addr(), pick_gap(quiet), 1'b0);
            end else if (r < 89) begin
                add_traced(ACT_EXIT, rand_addr(), pick_gap(quiet), 1'b0);
            end else if (r < 92) begin
                add_traced(ACT_ENTER, rand_addr(), pick_gap(quiet), 1'b0);
            end else if (r < 95) begin
                add_traced(ACT_EXIT, pool[$urandom_range(0, 15)], pick_gap(quiet), 1'b0);
            end else if (r < 97) begin
                add_event(ACT_NONE, rand_addr(), $urandom, 20'($urandom),
                          pick_gap(quiet), 1'b0);
            end else begin
                // Arbitrary timestamp, may run backwards or exceed the usec range
                add_event(($urandom_range(0, 1) == 0) ? ACT_ENTER : ACT_EXIT,
                          pool[$urandom_range(0, 15)], $urandom,
                          20'($urandom_range(0, 20'hFFFFF)), pick_gap(quiet), 1'b0);
            end
        end
    endfunction

    initial begin : stimulus
        logic [63:0] pool[16];
        logic [63:0] open_calls[$];

        trace_sec  = $urandom_range(1, 1000);
        trace_usec = '0;
        for (int k = 0; k < 16; k++) pool[k] = rand_addr();

        // Directed corner cases
        add_event(ACT_DUMP,  64'd0, 32'd0, 20'd0, 0, 1'b0);
        add_event(ACT_NONE,  '1, '1, '1, 0, 1'b0);
        add_event(ACT_EXIT,  64'd0, 32'd0, 20'd0, 2, 1'b0);
        add_event(ACT_ENTER, 64'd0, 32'd0, 20'd0, 0, 1'b0);
        add_event(ACT_ENTER, '1, '1, 20'd999999, 0, 1'b0);
        add_event(ACT_ENTER, 64'd0, 32'd1, 20'd5, 1, 1'b0);
        add_event(ACT_EXIT,  64'd0, 32'd2, 20'd7, 0, 1'b0);
        add_event(ACT_EXIT,  64'd0, 32'd5, 20'hFFFFF, 0, 1'b0);
        add_event(ACT_EXIT,  64'd0, 32'd9, 20'd123456, 3, 1'b0);
        add_event(ACT_ENTER, 64'd0, 32'd10, 20'd0, 0, 1'b0);
        add_event(ACT_EXIT,  '1, 32'd0, 20'd0, 0, 1'b0);
        add_event(ACT_DUMP,  64'd0, 32'd0, 20'd0, 0, 1'b0);
        add_event(ACT_DUMP,  '1, '1, '1, 7, 1'b0);
        add_event(ACT_EXIT,  64'h8000_0000_0000_0001, '1, 20'hFFFFF, 0, 1'b0);
        add_event(ACT_NONE,  rand_addr(), $urandom, 20'($urandom), 0, 1'b0);

        // Random traces before the table fills
        add_random_trace(50, pool, open_calls);

        // Fill the table past capacity after the pipeline drains
        for (int k = 0; k < 70; k++) begin
            add_traced(ACT_ENTER, {16'hF11F, 16'(k), $urandom}, pick_gap(k < 30), k == 0);
        end
        add_traced(ACT_DUMP, 64'd0, 0, 1'b0);

        // Nest one function several levels deep, then unwind one level
        for (int k = 0; k < BURST_LEN; k++) begin
            add_traced(ACT_ENTER, 64'd0, 0, k == 0);
        end
        add_traced(ACT_EXIT, 64'd0, 0, 1'b0);
        add_traced(ACT_DUMP, 64'd0, 2, 1'b0);

        // Random traces against a full table
        add_random_trace(20, pool, open_calls);
        add_traced(ACT_DUMP, 64'd0, 0, 1'b0);

        // Drain: all stimulus taken, all reports in, then let the tail settle
        wait (i_rst_n);
        while (pending_events.size() != 0 || staged || driving) @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: present events at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // Retire the event transferred at the last rising edge
            if (took) begin
                took    = 1'b0;
                driving = 1'b0;
            end
            if (!driving && !staged && pending_events.size() != 0) begin
                cur_event = pending_events.pop_front();
                staged    = 1'b1;
                hold_cnt  = cur_event.gap;
            end
            if (staged) begin
                if (hold_cnt > 0) begin
                    hold_cnt--;
                end else if (!cur_event.hold || expected_reports.size() == 0) begin
                    staged  = 1'b0;
                    driving = 1'b1;
                end
            end
            start <= driving;
            // Idle cycles carry noise on the payload
            if (driving) begin
                i_action        <= cur_event.action;
                i_function_addr <= cur_event.func;
                i_time_sec      <= cur_event.sec;
                i_time_usec     <= cur_event.usec;
            end else begin
                i_action        <= 2'($urandom);
                i_function_addr <= rand_addr();
                i_time_sec      <= $urandom;
                i_time_usec     <= 20'($urandom);
            end
        end
    end

    // Predict on each input transfer
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            profile_event(cur_event);
            took = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each strobed report with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected report: status %0d function %h total %0d",
                       o_status, o_entry_function, o_entry_total_time);
                error_cnt++;
            end else begin
                got_report = expected_reports.pop_front();
                if (o_status !== got_report.status) begin
                    $error("status: expected %0d, got %0d", got_report.status, o_status);
                    error_cnt++;
                end
                if (o_entry_function !== got_report.func) begin
                    $error("entry_function: expected %h, got %h",
                           got_report.func, o_entry_function);
                    error_cnt++;
                end
                if (o_entry_total_time !== got_report.total) begin
                    $error("entry_total_time: expected %0d, got %0d",
                           got_report.total, o_entry_total_time);
                    error_cnt++;
                end
                if (o_last_of_run !== got_report.last) begin
                    $error("last_of_run: expected %0b, got %0b",
                           got_report.last, o_last_of_run);
                    error_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
